>>> src/ast_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the alarm slot table
// no dependencies
package ast_pkg;

  localparam int unsigned SLOTS_DEF  = 16;
  localparam int unsigned MAX_FIRED  = 16;
  localparam int unsigned ID_W       = 31;
  localparam int unsigned TRIG_W     = 24;
  localparam int unsigned MS_W       = 48;
  localparam int unsigned DAY_W      = 16;
  localparam int unsigned SOD_W      = 17;
  localparam int unsigned FDAY_W     = 17;
  localparam int unsigned PROD_W     = 34;
  localparam logic [9:0]  MS_PER_SEC = 10'd1000;
  localparam logic [FDAY_W-1:0] NEVER_DAY = 17'h10000;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    RK_ADD    = 3'd0,
    RK_REMOVE = 3'd1,
    RK_CLEAR  = 3'd2,
    RK_FIRED  = 3'd3,
    RK_NONE   = 3'd4
  } result_kind_e;

  typedef struct packed {
    logic [ID_W-1:0]   ident;
    logic              kind;
    logic              enabled;
    logic [TRIG_W-1:0] trigger;
    logic [MS_W-1:0]   base_ms;
    logic [FDAY_W-1:0] fired_day;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

>>> src/ast_ram.sv
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
// no dependencies
module ast_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/ast_due_unit.sv
`timescale 1ns / 1ps
// due check of one slot: registered product and difference, then compare
// depends on ast_pkg
module ast_due_unit (
  input  logic                       clk_i,
  input  ast_pkg::entry_t            entry_i,
  input  logic [ast_pkg::MS_W-1:0]   now_ms_i,
  input  logic [ast_pkg::DAY_W-1:0]  day_i,
  input  logic [ast_pkg::SOD_W-1:0]  sod_i,
  output logic                       due_o
);

  logic [ast_pkg::MS_W:0]     diff;
  logic [ast_pkg::PROD_W-1:0] prod_q;
  logic [ast_pkg::MS_W-1:0]   diff_q;
  logic                       ge_q;
  logic                       abs_due_q;
  logic                       kind_q;
  logic                       en_q;
  logic                       rel_due;

  assign diff = {1'b0, now_ms_i} - {1'b0, entry_i.base_ms};

  always_ff @(posedge clk_i) begin
    prod_q    <= {{(ast_pkg::PROD_W - ast_pkg::TRIG_W){1'b0}}, entry_i.trigger}
                 * ast_pkg::PROD_W'(ast_pkg::MS_PER_SEC);
    diff_q    <= diff[ast_pkg::MS_W-1:0];
    ge_q      <= ~diff[ast_pkg::MS_W];
    abs_due_q <= ({7'd0, sod_i} >= entry_i.trigger)
                 && (entry_i.fired_day != {1'b0, day_i});
    kind_q    <= entry_i.kind;
    en_q      <= entry_i.enabled;
  end

  // clock going back counts as no time elapsed
  assign rel_due = ge_q ? (diff_q >= ast_pkg::MS_W'(prod_q)) : (prod_q == '0);
  assign due_o   = en_q && (kind_q ? abs_due_q : rel_due);

endmodule

>>> src/alarm_slot_table_core.sv
`timescale 1ns / 1ps
// alarm slot table top level: sequencer around the slot memory
// depends on ast_pkg, ast_ram, ast_due_unit
//
// usage
// - input channel in_valid_i / in_ready_o carries one command per transfer:
//   tick, add, remove or clear, with the current time fields
// - output channel out_valid_o / out_ready_i carries results; last_result_o
//   marks the final result of a command
// - one command at a time; in_ready_o is high only while the sequencer idles
// - add and clear: the command state writes the result to the output register
// - remove: each slot searched is read, then checked; each slot after the match is then read and written one place up
// - tick: each slot walked goes through memory read, multiply stage and compare
// - a tick holds back each fired result until the next due slot or the end
//   of the walk, so that the last one can carry the last flag
// - at most 16 alarms fire per tick, the rest wait for a later tick
// - reset empties the table and restarts ids; slot memory is not cleared,
//   only entries below the count are ever read
// - a stalled receiver holds the output register and the walk waits on it
module alarm_slot_table_core #(
  parameter int unsigned SLOTS = ast_pkg::SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    opcode_i,
  input  logic                          alarm_kind_i,
  input  logic [ast_pkg::TRIG_W-1:0]    trigger_seconds_i,
  input  logic [ast_pkg::ID_W-1:0]      target_id_i,
  input  logic [ast_pkg::MS_W-1:0]      now_ms_i,
  input  logic [ast_pkg::DAY_W-1:0]     day_index_i,
  input  logic [ast_pkg::SOD_W-1:0]     second_of_day_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    result_kind_o,
  output logic [ast_pkg::ID_W-1:0]      alarm_id_o,
  output logic                          fired_kind_o,
  output logic                          success_o,
  output logic                          last_result_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_TRD, S_TMUL, S_TEVAL, S_TFIN, S_ADD,
    S_RRD, S_RCHK, S_SRD, S_SWR, S_RESP
  } state_e;

  state_e state_q;

  // command fields held for the whole command
  logic                          kind_q;
  logic [ast_pkg::TRIG_W-1:0]    trig_q;
  logic [ast_pkg::ID_W-1:0]      target_q;
  logic [ast_pkg::MS_W-1:0]      now_q;
  logic [ast_pkg::DAY_W-1:0]     day_q;
  logic [ast_pkg::SOD_W-1:0]     sod_q;

  logic [CntW-1:0]               cnt_q;
  logic [ast_pkg::ID_W-1:0]      id_q;
  logic [IdxW-1:0]               idx_q;
  logic [4:0]                    nfired_q;

  // fired result held back until its last flag is known
  logic                          hold_q;
  logic [ast_pkg::ID_W-1:0]      hold_id_q;
  logic                          hold_kind_q;

  ast_pkg::result_kind_e         resp_kind_q;
  logic                          resp_ok_q;

  // output register
  logic                          out_valid_q;
  logic [2:0]                    out_kind_q;
  logic [ast_pkg::ID_W-1:0]      out_id_q;
  logic                          out_fk_q;
  logic                          out_ok_q;
  logic                          out_last_q;

  // memory ports
  logic                          mem_we;
  logic [IdxW-1:0]               mem_waddr;
  ast_pkg::entry_t               mem_wdata;
  logic [IdxW-1:0]               mem_raddr;
  ast_pkg::entry_t               rd_entry;
  logic [ast_pkg::ENTRY_W-1:0]   rd_bits;

  logic                          due;
  logic                          out_free;
  logic                          stall;
  logic [CntW-1:0]               idx_ext;
  logic [CntW-1:0]               idx_nxt;
  logic [4:0]                    nf_nxt;
  logic [ast_pkg::ID_W-1:0]      new_id;

  assign out_free = !out_valid_q || out_ready_i;
  assign idx_ext  = CntW'(idx_q);
  assign idx_nxt  = idx_ext + CntW'(1);
  assign new_id   = id_q + ast_pkg::ID_W'(1);
  assign stall    = due && hold_q && !out_free;
  assign nf_nxt   = nfired_q + {4'd0, due};
  assign rd_entry = ast_pkg::entry_t'(rd_bits);

  // a shift reads the slot after the one being written
  assign mem_raddr = (state_q == S_SRD) ? IdxW'(idx_nxt) : idx_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = rd_entry;
    case (state_q)
      S_TEVAL: begin
        mem_we = due && !stall;
        if (rd_entry.kind) begin
          mem_wdata.fired_day = {1'b0, day_q};
        end else begin
          mem_wdata.enabled = 1'b0;
        end
      end
      S_ADD: begin
        mem_we              = out_free && (cnt_q < CntW'(SLOTS));
        mem_waddr           = IdxW'(cnt_q);
        mem_wdata.ident     = new_id;
        mem_wdata.kind      = kind_q;
        mem_wdata.enabled   = 1'b1;
        mem_wdata.trigger   = trig_q;
        mem_wdata.base_ms   = kind_q ? '0 : now_q;
        // an absolute alarm already past today counts as fired today
        mem_wdata.fired_day = (kind_q && ({7'd0, sod_q} >= trig_q))
                              ? {1'b0, day_q} : ast_pkg::NEVER_DAY;
      end
      S_SWR: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  ast_ram #(
    .Width (ast_pkg::ENTRY_W),
    .Depth (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rd_bits)
  );

  ast_due_unit u_due (
    .clk_i    (clk_i),
    .entry_i  (rd_entry),
    .now_ms_i (now_q),
    .day_i    (day_q),
    .sod_i    (sod_q),
    .due_o    (due)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      id_q        <= '0;
      idx_q       <= '0;
      nfired_q    <= '0;
      hold_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q   <= alarm_kind_i;
            trig_q   <= trigger_seconds_i;
            target_q <= target_id_i;
            now_q    <= now_ms_i;
            day_q    <= day_index_i;
            sod_q    <= second_of_day_i;
            idx_q    <= '0;
            nfired_q <= '0;
            hold_q   <= 1'b0;
            case (ast_pkg::opcode_e'(opcode_i))
              ast_pkg::OP_TICK: begin
                state_q <= (cnt_q == '0) ? S_TFIN : S_TRD;
              end
              ast_pkg::OP_ADD: begin
                state_q <= S_ADD;
              end
              ast_pkg::OP_REMOVE: begin
                resp_kind_q <= ast_pkg::RK_REMOVE;
                resp_ok_q   <= 1'b0;
                state_q     <= (cnt_q == '0) ? S_RESP : S_RRD;
              end
              default: begin
                cnt_q       <= '0;
                resp_kind_q <= ast_pkg::RK_CLEAR;
                resp_ok_q   <= 1'b0;
                state_q     <= S_RESP;
              end
            endcase
          end
        end
        S_TRD: begin
          state_q <= S_TMUL;
        end
        S_TMUL: begin
          state_q <= S_TEVAL;
        end
        S_TEVAL: begin
          if (!stall) begin
            if (due) begin
              if (hold_q) begin
                out_valid_q <= 1'b1;
                out_kind_q  <= ast_pkg::RK_FIRED;
                out_id_q    <= hold_id_q;
                out_fk_q    <= hold_kind_q;
                out_ok_q    <= 1'b0;
                out_last_q  <= 1'b0;
              end
              hold_q      <= 1'b1;
              hold_id_q   <= rd_entry.ident;
              hold_kind_q <= rd_entry.kind;
              nfired_q    <= nf_nxt;
            end
            if (idx_nxt == cnt_q || nf_nxt == 5'(ast_pkg::MAX_FIRED)) begin
              state_q <= S_TFIN;
            end else begin
              idx_q   <= IdxW'(idx_nxt);
              state_q <= S_TRD;
            end
          end
        end
        S_TFIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= hold_q ? ast_pkg::RK_FIRED : ast_pkg::RK_NONE;
            out_id_q    <= hold_q ? hold_id_q : '0;
            out_fk_q    <= hold_q && hold_kind_q;
            out_ok_q    <= 1'b0;
            out_last_q  <= 1'b1;
            hold_q      <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        S_ADD: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= ast_pkg::RK_ADD;
            out_fk_q    <= 1'b0;
            out_last_q  <= 1'b1;
            if (cnt_q < CntW'(SLOTS)) begin
              id_q     <= new_id;
              cnt_q    <= cnt_q + CntW'(1);
              out_id_q <= new_id;
              out_ok_q <= 1'b1;
            end else begin
              out_id_q <= '0;
              out_ok_q <= 1'b0;
            end
            state_q <= S_IDLE;
          end
        end
        S_RRD: begin
          state_q <= S_RCHK;
        end
        S_RCHK: begin
          if (rd_entry.ident == target_q) begin
            if (idx_nxt < cnt_q) begin
              state_q <= S_SRD;
            end else begin
              cnt_q     <= cnt_q - CntW'(1);
              resp_ok_q <= 1'b1;
              state_q   <= S_RESP;
            end
          end else if (idx_nxt == cnt_q) begin
            state_q <= S_RESP;
          end else begin
            idx_q   <= IdxW'(idx_nxt);
            state_q <= S_RRD;
          end
        end
        S_SRD: begin
          state_q <= S_SWR;
        end
        S_SWR: begin
          // close the gap one slot at a time
          idx_q <= IdxW'(idx_nxt);
          if (idx_nxt + CntW'(1) < cnt_q) begin
            state_q <= S_SRD;
          end else begin
            cnt_q     <= cnt_q - CntW'(1);
            resp_ok_q <= 1'b1;
            state_q   <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= resp_kind_q;
            out_id_q    <= '0;
            out_fk_q    <= 1'b0;
            out_ok_q    <= resp_ok_q;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign alarm_id_o    = out_id_q;
  assign fired_kind_o  = out_fk_q;
  assign success_o     = out_ok_q;
  assign last_result_o = out_last_q;

  // the table never holds more than its slots
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(SLOTS))
    else $error("entry count above table size");

  // no more fired alarms in one tick than the output limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    nfired_q <= 5'(ast_pkg::MAX_FIRED))
    else $error("fired count above limit");

  // an accepted command always leaves the idle state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("command accepted without being started");

  // a held fired result is only ever present during a tick walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q |-> (state_q == S_TRD || state_q == S_TMUL || state_q == S_TEVAL
                || state_q == S_TFIN))
    else $error("fired result held outside a tick");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for alarm_slot_table_core: queued command driver, result monitor
// depends on ast_pkg and the alarm_slot_table_core rtl
module tb_top;

  localparam int unsigned NSLOT    = 16;
  localparam int unsigned N_ITEMS  = 260;
  localparam int unsigned WD_LIMIT = 3000;

  typedef struct {
    ast_pkg::opcode_e           op;
    logic                       kind;
    logic [ast_pkg::TRIG_W-1:0] trig;
    logic [ast_pkg::ID_W-1:0]   tid;
    logic [ast_pkg::MS_W-1:0]   ms;
    logic [ast_pkg::DAY_W-1:0]  day;
    logic [ast_pkg::SOD_W-1:0]  sod;
  } cmd_t;

  typedef struct {
    ast_pkg::result_kind_e    rk;
    logic [ast_pkg::ID_W-1:0] id;
    logic                     fk;
    logic                     ok;
    logic                     last;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  // clock: high then low, 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic in_valid = 1'b0;
  logic in_ready;
  cmd_t cur_cmd = '{ast_pkg::OP_TICK, 1'b0, '0, '0, '0, '0, '0};
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] rk_o;
  logic [ast_pkg::ID_W-1:0] id_o;
  logic fk_o, ok_o, last_o;

  alarm_slot_table_core DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .opcode_i          (cur_cmd.op),
    .alarm_kind_i      (cur_cmd.kind),
    .trigger_seconds_i (cur_cmd.trig),
    .target_id_i       (cur_cmd.tid),
    .now_ms_i          (cur_cmd.ms),
    .day_index_i       (cur_cmd.day),
    .second_of_day_i   (cur_cmd.sod),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .result_kind_o     (rk_o),
    .alarm_id_o        (id_o),
    .fired_kind_o      (fk_o),
    .success_o         (ok_o),
    .last_result_o     (last_o)
  );

  // shadow of the alarm table
  logic [ast_pkg::ID_W-1:0]   sh_id   [NSLOT];
  logic                       sh_kind [NSLOT];
  logic                       sh_en   [NSLOT];
  logic [ast_pkg::TRIG_W-1:0] sh_trig [NSLOT];
  logic [ast_pkg::MS_W-1:0]   sh_base [NSLOT];
  logic [ast_pkg::FDAY_W-1:0] sh_fday [NSLOT];
  int unsigned                sh_count = 0;
  logic [ast_pkg::ID_W-1:0]   last_id  = '0;

  cmd_t pend_q[$];
  res_t exp_q[$];
  int   errors = 0;
  int   mismatches = 0;

  function automatic void append_cmd(cmd_t c);
    pend_q = {pend_q, c};
  endfunction

  function automatic logic alarm_due(int i, cmd_t c);
    logic [ast_pkg::MS_W-1:0] secs;
    if (!sh_en[i]) return 1'b0;
    if (sh_kind[i] == 1'b0) begin
      secs = (c.ms >= sh_base[i]) ? (c.ms - sh_base[i]) / 1000 : '0;
      return secs >= ast_pkg::MS_W'(sh_trig[i]);
    end
    return (ast_pkg::TRIG_W'(c.sod) >= sh_trig[i]) && (sh_fday[i] != {1'b0, c.day});
  endfunction

  function automatic void add_result(ast_pkg::result_kind_e rk,
                                     logic [ast_pkg::ID_W-1:0] id, logic fk, logic ok);
    res_t r;
    r = '{rk, id, fk, ok, 1'b0};
    exp_q = {exp_q, r};
  endfunction

  // expected results of one accepted command, table updated in step
  function automatic void predict_alarm_results(cmd_t c);
    int n;
    bit found;
    n = 0;
    found = 0;
    case (c.op)
      ast_pkg::OP_TICK: begin
        for (int i = 0; i < sh_count && n < ast_pkg::MAX_FIRED; i++) begin
          if (alarm_due(i, c)) begin
            add_result(ast_pkg::RK_FIRED, sh_id[i], sh_kind[i], 1'b0);
            n++;
            if (sh_kind[i] == 1'b0) sh_en[i] = 1'b0;
            else sh_fday[i] = {1'b0, c.day};
          end
        end
        if (n == 0) add_result(ast_pkg::RK_NONE, '0, 1'b0, 1'b0);
      end
      ast_pkg::OP_ADD: begin
        if (sh_count >= NSLOT) begin
          add_result(ast_pkg::RK_ADD, '0, 1'b0, 1'b0);
        end else begin
          last_id = last_id + 1'b1;
          sh_id[sh_count]   = last_id;
          sh_kind[sh_count] = c.kind;
          sh_en[sh_count]   = 1'b1;
          sh_trig[sh_count] = c.trig;
          sh_base[sh_count] = c.kind ? '0 : c.ms;
          sh_fday[sh_count] = (c.kind && ast_pkg::TRIG_W'(c.sod) >= c.trig)
                              ? {1'b0, c.day} : ast_pkg::NEVER_DAY;
          sh_count++;
          add_result(ast_pkg::RK_ADD, last_id, 1'b0, 1'b1);
        end
      end
      ast_pkg::OP_REMOVE: begin
        for (int i = 0; i < sh_count && !found; i++) begin
          if (sh_id[i] == c.tid) begin
            for (int j = i; j + 1 < sh_count; j++) begin
              sh_id[j]   = sh_id[j+1];
              sh_kind[j] = sh_kind[j+1];
              sh_en[j]   = sh_en[j+1];
              sh_trig[j] = sh_trig[j+1];
              sh_base[j] = sh_base[j+1];
              sh_fday[j] = sh_fday[j+1];
            end
            sh_count--;
            found = 1;
          end
        end
        add_result(ast_pkg::RK_REMOVE, '0, 1'b0, found);
      end
      default: begin
        sh_count = 0;
        add_result(ast_pkg::RK_CLEAR, '0, 1'b0, 1'b0);
      end
    endcase
    exp_q[exp_q.size()-1].last = 1'b1;
  endfunction

  // stimulus generation: a running wall clock and monotonic time
  logic [ast_pkg::MS_W-1:0]  gen_ms  = '0;
  logic [ast_pkg::DAY_W-1:0] gen_day = '0;
  logic [ast_pkg::SOD_W-1:0] gen_sod = '0;
  int unsigned               gen_adds = 0;

  function automatic void queue_cmd(ast_pkg::opcode_e op, logic kind,
                                    logic [ast_pkg::TRIG_W-1:0] trig,
                                    logic [ast_pkg::ID_W-1:0] tid);
    if (op == ast_pkg::OP_ADD) gen_adds++;
    append_cmd('{op, kind, trig, tid, gen_ms, gen_day, gen_sod});
  endfunction

  function automatic void advance_clock(int unsigned ms);
    gen_ms = gen_ms + ms;
    gen_sod = gen_sod + ast_pkg::SOD_W'(ms / 1000);
    if (gen_sod >= 86400) begin
      gen_sod = gen_sod - 86400;
      gen_day = gen_day + 1'b1;
    end
  endfunction

  function automatic logic [ast_pkg::TRIG_W-1:0] noise_trig();
    return ast_pkg::TRIG_W'($urandom);
  endfunction

  function automatic logic [ast_pkg::ID_W-1:0] noise_id();
    return ast_pkg::ID_W'($urandom);
  endfunction

  function automatic logic noise_bit();
    return 1'($urandom);
  endfunction

  function automatic void fill_pending();
    int r;
    int unsigned t;
    cmd_t c;
    // directed: empty table, one-shot, daily, out of range, absent id, time going back
    queue_cmd(ast_pkg::OP_TICK, 1'b1, '1, '1);
    queue_cmd(ast_pkg::OP_ADD, 1'b0, '0, noise_id());
    queue_cmd(ast_pkg::OP_TICK, 1'b0, noise_trig(), noise_id());
    queue_cmd(ast_pkg::OP_TICK, 1'b0, noise_trig(), noise_id());
    gen_sod = 17'd100;
    queue_cmd(ast_pkg::OP_ADD, 1'b1, 24'd102, '1);
    queue_cmd(ast_pkg::OP_ADD, 1'b1, '0, '0);
    queue_cmd(ast_pkg::OP_ADD, 1'b1, '1, noise_id());
    queue_cmd(ast_pkg::OP_ADD, 1'b0, '1, noise_id());
    gen_ms = 48'd5000;
    queue_cmd(ast_pkg::OP_ADD, 1'b0, 24'd2, noise_id());
    queue_cmd(ast_pkg::OP_REMOVE, 1'b0, noise_trig(), '1);
    queue_cmd(ast_pkg::OP_REMOVE, 1'b1, '1, 31'd1);
    advance_clock(3000);
    queue_cmd(ast_pkg::OP_TICK, 1'b1, noise_trig(), noise_id());
    queue_cmd(ast_pkg::OP_ADD, 1'b0, 24'd1, noise_id());
    c = '{ast_pkg::OP_TICK, 1'b0, '0, '0, 48'd10, gen_day, gen_sod};
    append_cmd(c);
    queue_cmd(ast_pkg::OP_TICK, 1'b0, '0, '0);
    gen_day = gen_day + 1'b1;
    queue_cmd(ast_pkg::OP_TICK, 1'b0, '0, '0);
    c = '{ast_pkg::OP_TICK, 1'b1, '1, '1, '1, '1, 17'd86399};
    append_cmd(c);
    queue_cmd(ast_pkg::OP_CLEAR, 1'b1, '1, '1);
    queue_cmd(ast_pkg::OP_TICK, 1'b0, '0, '0);

    // random part from a random epoch
    gen_ms  = ast_pkg::MS_W'({$urandom, $urandom}) & 48'h7FFF_FFFF_FFFF;
    gen_day = ast_pkg::DAY_W'($urandom);
    gen_sod = ast_pkg::SOD_W'($urandom_range(0, 86399));
    while (pend_q.size() < N_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 33) begin
        if ($urandom_range(0, 1) == 0) begin
          t = ($urandom_range(0, 9) == 0) ? noise_trig() : $urandom_range(0, 4);
          queue_cmd(ast_pkg::OP_ADD, 1'b0, ast_pkg::TRIG_W'(t), noise_id());
        end else begin
          t = ($urandom_range(0, 9) == 0) ? noise_trig()
                                          : gen_sod + $urandom_range(0, 8) - 3;
          queue_cmd(ast_pkg::OP_ADD, 1'b1, ast_pkg::TRIG_W'(t), noise_id());
        end
      end else if (r < 68) begin
        advance_clock($urandom_range(0, 2500));
        if ($urandom_range(0, 19) == 0) begin
          c = '{ast_pkg::OP_TICK, noise_bit(), noise_trig(), noise_id(),
                gen_ms - $urandom_range(1, 9000), gen_day, gen_sod};
          append_cmd(c);
        end else begin
          queue_cmd(ast_pkg::OP_TICK, noise_bit(), noise_trig(), noise_id());
        end
      end else if (r < 86) begin
        t = ($urandom_range(0, 14) == 0) ? noise_id() : $urandom_range(0, gen_adds + 1);
        queue_cmd(ast_pkg::OP_REMOVE, noise_bit(), noise_trig(), ast_pkg::ID_W'(t));
      end else if (r < 90) begin
        queue_cmd(ast_pkg::OP_CLEAR, noise_bit(), noise_trig(), noise_id());
      end else if (r < 94) begin
        // fill the table past full, then let everything fire at once
        for (int k = 0; k < 17; k++) queue_cmd(ast_pkg::OP_ADD, 1'b0, '0, noise_id());
        queue_cmd(ast_pkg::OP_TICK, 1'b0, '0, '0);
      end else begin
        // jump close to midnight so the day rolls over
        gen_sod = ast_pkg::SOD_W'(86399 - $urandom_range(0, 3));
        advance_clock(4000);
        queue_cmd(ast_pkg::OP_TICK, noise_bit(), noise_trig(), noise_id());
      end
    end
  endfunction

  // no idling near the end of the run
  function automatic bit quiet_phase();
    return pend_q.size() < 30;
  endfunction

  int unsigned in_gap = 0;
  int unsigned out_gap = 0;

  // driver: predict on each transfer, then present the next pending command
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && in_ready) predict_alarm_results(cur_cmd);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          cur_cmd <= pend_q.pop_front();
          in_valid <= 1'b1;
          if (!quiet_phase() && $urandom_range(0, 7) == 0) in_gap <= $urandom_range(1, 13);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    res_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (exp_q.size() == 0) begin
          errors++;
          if (mismatches < 10) $display("unexpected result kind %0d id %0d", rk_o, id_o);
          mismatches++;
        end else begin
          e = exp_q.pop_front();
          if (rk_o !== e.rk || id_o !== e.id || fk_o !== e.fk || ok_o !== e.ok ||
              last_o !== e.last) begin
            errors++;
            if (mismatches < 10)
              $display("mismatch: exp kind %0d id %0d fk %0d ok %0d last %0d, %s",
                       e.rk, e.id, e.fk, e.ok, e.last,
                       $sformatf("got %0d %0d %0d %0d %0d",
                                 rk_o, id_o, fk_o, ok_o, last_o));
            mismatches++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet_phase() && $urandom_range(0, 7) == 0) out_gap <= $urandom_range(1, 13);
      end
    end
  end

  // watchdog on cycles without any transfer
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    fill_pending();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_n = 1'b1;
    while (pend_q.size() > 0 || in_valid || exp_q.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && exp_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
src/ast_pkg.sv
src/ast_ram.sv
src/ast_due_unit.sv
src/alarm_slot_table_core.sv
test/tb_top.sv
